FILE: design/dpbp_pkg.sv
// ----------------------------------------------------------------------------
// dpbp_pkg
// Shared types and constants of the depth back-projection unit: register
// indexes, register reset values and the bundles that pass between modules.
// ----------------------------------------------------------------------------
package dpbp_pkg;

	// Configuration register indexes
	localparam int          CFG_INDEX_W      = 3;
	localparam int          CFG_DATA_W       = 24;
	localparam logic [2:0]  REG_FRAME_WIDTH  = 3'd0;
	localparam logic [2:0]  REG_FRAME_HEIGHT = 3'd1;
	localparam logic [2:0]  REG_INV_FOCAL_X  = 3'd2;
	localparam logic [2:0]  REG_INV_FOCAL_Y  = 3'd3;
	localparam logic [2:0]  REG_CENTER_X     = 3'd4;
	localparam logic [2:0]  REG_CENTER_Y     = 3'd5;

	// Register values after reset
	localparam logic [10:0] RST_FRAME_WIDTH  = 11'd512;
	localparam logic [10:0] RST_FRAME_HEIGHT = 11'd424;
	localparam logic [23:0] RST_INV_FOCAL    = 24'd45964;
	localparam logic [13:0] RST_CENTER_X     = 14'd4096;
	localparam logic [13:0] RST_CENTER_Y     = 14'd3392;

	// Field widths
	localparam int DEPTH_W    = 16;
	localparam int CENTER_W   = 14;
	localparam int COUNT_W    = 21;
	localparam int COORD_W    = 32;
	localparam int POINT_Z_W  = 20;

	// Entries in the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Camera and frame configuration
	typedef struct packed {
		logic [10:0] frame_width;
		logic [10:0] frame_height;
		logic [23:0] inv_focal_x;
		logic [23:0] inv_focal_y;
		logic [13:0] center_x;
		logic [13:0] center_y;
	} cfg_t;

	// Per-pixel bookkeeping carried alongside the arithmetic
	typedef struct packed {
		logic [15:0] depth;
		logic [20:0] valid_so_far;
		logic        frame_last;
	} meta_t;

	localparam int META_W = $bits(meta_t);

endpackage

FILE: design/dpbp_queue.sv
// ----------------------------------------------------------------------------
// dpbp_queue
// Small first-in first-out queue that decouples the pixel front end from the
// projection pipeline.
// ----------------------------------------------------------------------------
module dpbp_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             empty,
	output logic             full
);

	localparam int PTR_W = $clog2(dpbp_pkg::QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	logic [WIDTH-1:0] mem_q [dpbp_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(dpbp_pkg::QUEUE_DEPTH));
	assign head_data = mem_q[rd_ptr_q];

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(dpbp_pkg::QUEUE_DEPTH))
		else $error("queue occupancy beyond its depth");

endmodule

FILE: design/dpbp_front.sv
// ----------------------------------------------------------------------------
// dpbp_front
// Pixel front end: tracks column, row and valid count, classifies each depth
// word and forms the signed pixel offsets from the principal point.
// ----------------------------------------------------------------------------
module dpbp_front #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024,
	parameter int MAG_W    = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dpbp_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [15:0]          depth_mm,
	input  logic                 queue_full,
	output logic                 push,
	output logic                 neg_x,
	output logic [MAG_W-1:0]     mag_x,
	output logic                 neg_y,
	output logic [MAG_W-1:0]     mag_y,
	output dpbp_pkg::meta_t      meta
);

	localparam int CW     = $clog2(MAX_COLS);
	localparam int RW     = $clog2(MAX_ROWS);
	localparam int MAXW   = (CW > RW) ? CW : RW;
	localparam int DIM_W  = (MAXW + 1 > 11) ? MAXW + 1 : 11;

	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [20:0]      total_q;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic             row_end;
	logic             last;
	logic             nonzero;
	logic [20:0]      count_now;

	// Offset of a pixel from the principal point: sign and magnitude, Q.4
	function automatic logic [MAG_W:0] axis_offset(
		input logic [MAG_W-1:0] pos16,
		input logic [13:0]      center
	);
		logic signed [MAG_W:0] diff;
		logic signed [MAG_W:0] mag;
		diff = $signed({1'b0, pos16}) - $signed({1'b0, MAG_W'(center)});
		mag  = diff[MAG_W] ? -diff : diff;
		return {diff[MAG_W], mag[MAG_W-1:0]};
	endfunction

	// Clamp frame geometry to the supported range
	always_comb begin
		if (cfg.frame_width == '0) begin
			w_eff = DIM_W'(1);
		end else if (DIM_W'(cfg.frame_width) > DIM_W'(MAX_COLS)) begin
			w_eff = DIM_W'(MAX_COLS);
		end else begin
			w_eff = DIM_W'(cfg.frame_width);
		end
		if (cfg.frame_height == '0) begin
			h_eff = DIM_W'(1);
		end else if (DIM_W'(cfg.frame_height) > DIM_W'(MAX_ROWS)) begin
			h_eff = DIM_W'(MAX_ROWS);
		end else begin
			h_eff = DIM_W'(cfg.frame_height);
		end
	end

	// Classify the pixel
	assign row_end   = DIM_W'(col_q) >= (w_eff - DIM_W'(1));
	assign last      = row_end && (DIM_W'(row_q) >= (h_eff - DIM_W'(1)));
	assign nonzero   = (depth_mm != '0);
	assign count_now = nonzero ? (total_q + 21'd1) : total_q;

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	assign {neg_x, mag_x} = axis_offset(MAG_W'({col_q, 4'b0000}), cfg.center_x);
	assign {neg_y, mag_y} = axis_offset(MAG_W'({row_q, 4'b0000}), cfg.center_y);

	assign meta.depth        = depth_mm;
	assign meta.valid_so_far = count_now;
	assign meta.frame_last   = last;

	// Advance raster position and valid count on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			total_q <= '0;
		end else if (push) begin
			if (last) begin
				col_q   <= '0;
				row_q   <= '0;
				total_q <= '0;
			end else if (row_end) begin
				col_q   <= '0;
				row_q   <= row_q + RW'(1);
				total_q <= count_now;
			end else begin
				col_q   <= col_q + CW'(1);
				total_q <= count_now;
			end
		end
	end

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		push && last |=> col_q == '0 && row_q == '0 && total_q == '0)
		else $error("counters not cleared after last pixel of frame");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CW + 1)'(col_q) < (CW + 1)'(MAX_COLS) && (RW + 1)'(row_q) < (RW + 1)'(MAX_ROWS))
		else $error("raster position out of range");

endmodule

FILE: design/dpbp_back.sv
// ----------------------------------------------------------------------------
// dpbp_back
// Projection pipeline: offset times depth, times reciprocal focal length in
// two partial products, rounding, then saturation into the output register.
// ----------------------------------------------------------------------------
module dpbp_back #(
	parameter int MAG_W = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dpbp_pkg::cfg_t       cfg,
	input  logic                 queue_empty,
	output logic                 pop,
	input  logic                 neg_x,
	input  logic [MAG_W-1:0]     mag_x,
	input  logic                 neg_y,
	input  logic [MAG_W-1:0]     mag_y,
	input  dpbp_pkg::meta_t      meta,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   point_x,
	output logic signed [31:0]   point_y,
	output logic [19:0]          point_z,
	output logic                 point_valid,
	output logic [20:0]          valid_so_far,
	output logic                 frame_last
);

	localparam int PW   = MAG_W + dpbp_pkg::DEPTH_W;
	localparam int PPW  = PW + 12;
	localparam int SUMW = PW + 25;
	localparam int QW   = SUMW - 24;

	logic            adv;
	logic            v_s1, v_s2, v_s3, out_valid_q;

	logic [PW-1:0]   prod_x_s1, prod_y_s1;
	logic            neg_x_s1, neg_y_s1, neg_x_s2, neg_y_s2, neg_x_s3, neg_y_s3;
	dpbp_pkg::meta_t meta_s1, meta_s2, meta_s3;

	logic [PPW-1:0]  lo_x_s2, hi_x_s2, lo_y_s2, hi_y_s2;
	logic [SUMW-1:0] sum_x, sum_y;
	logic [QW-1:0]   q_x_s3, q_y_s3;

	logic [31:0]     point_x_q, point_y_q;
	logic [19:0]     point_z_q;
	logic            point_valid_q;
	logic [20:0]     valid_so_far_q;
	logic            frame_last_q;

	// Restore sign and saturate to the signed 32-bit range
	function automatic logic [31:0] sat_axis(input logic neg, input logic [QW-1:0] q);
		logic [63:0] q64;
		q64 = 64'(q);
		if (neg) begin
			return (q64 > 64'h8000_0000) ? 32'h8000_0000 : -q64[31:0];
		end
		return (q64 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q64[31:0];
	endfunction

	// Whole pipe moves unless the output word is held
	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && !queue_empty;

	// Round to nearest, ties away from zero, on the magnitude
	assign sum_x = (SUMW'(hi_x_s2) << 12) + SUMW'(lo_x_s2) + (SUMW'(1) << 23);
	assign sum_y = (SUMW'(hi_y_s2) << 12) + SUMW'(lo_y_s2) + (SUMW'(1) << 23);

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		if (adv) begin
			// offset times depth
			prod_x_s1 <= PW'(mag_x) * PW'(meta.depth);
			prod_y_s1 <= PW'(mag_y) * PW'(meta.depth);
			neg_x_s1  <= neg_x;
			neg_y_s1  <= neg_y;
			meta_s1   <= meta;
			// partial products with the reciprocal focal length
			lo_x_s2   <= PPW'(prod_x_s1) * PPW'(cfg.inv_focal_x[11:0]);
			hi_x_s2   <= PPW'(prod_x_s1) * PPW'(cfg.inv_focal_x[23:12]);
			lo_y_s2   <= PPW'(prod_y_s1) * PPW'(cfg.inv_focal_y[11:0]);
			hi_y_s2   <= PPW'(prod_y_s1) * PPW'(cfg.inv_focal_y[23:12]);
			neg_x_s2  <= neg_x_s1;
			neg_y_s2  <= neg_y_s1;
			meta_s2   <= meta_s1;
			// combine and scale by 2^-24
			q_x_s3    <= sum_x[SUMW-1:24];
			q_y_s3    <= sum_y[SUMW-1:24];
			neg_x_s3  <= neg_x_s2;
			neg_y_s3  <= neg_y_s2;
			meta_s3   <= meta_s2;
			// output word
			point_x_q      <= sat_axis(neg_x_s3, q_x_s3);
			point_y_q      <= sat_axis(neg_y_s3, q_y_s3);
			point_z_q      <= {meta_s3.depth, 4'b0000};
			point_valid_q  <= (meta_s3.depth != '0);
			valid_so_far_q <= meta_s3.valid_so_far;
			frame_last_q   <= meta_s3.frame_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign point_x      = $signed(point_x_q);
	assign point_y      = $signed(point_y_q);
	assign point_z      = point_z_q;
	assign point_valid  = point_valid_q;
	assign valid_so_far = valid_so_far_q;
	assign frame_last   = frame_last_q;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !queue_empty)
		else $error("pop from empty queue");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !point_valid_q |-> point_x_q == '0 && point_y_q == '0 &&
			point_z_q == '0)
		else $error("invalid point carries nonzero coordinates");

	a_valid_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && point_valid_q |-> point_z_q != '0 && valid_so_far_q != '0 ||
			out_valid_q && point_valid_q && point_z_q != '0)
		else $error("valid point without depth");

endmodule

FILE: design/depth_to_point_backprojection_unit.sv
// ----------------------------------------------------------------------------
// depth_to_point_backprojection_unit
// Back-projects raster-order depth pixels through a pinhole camera model.
//
// Input channel (in_valid / in_stall / depth_mm): one depth word per pixel,
// row by row, left to right. Output channel (out_valid / out_stall / point_*):
// one point word per pixel, in the same order, with the running valid count
// and a last-of-frame mark. Configuration (cfg_write / cfg_index / cfg_data)
// is to be written only while no pixel is in flight; the block does not enforce this.
// Path: an accepted word goes through a four-entry queue, then stages s1, s2,
// s3 and the output register of the four-stage back-end multiply pipeline.
// Throughput: one word per cycle unless out_stall holds the output word.
// Reset: registers return to their default geometry and optics, the raster
// counters and valid count clear, and the queue and pipeline empty.
// Output stall: the whole back pipeline holds; the queue absorbs up to four
// more words, after which in_stall rises.
// ----------------------------------------------------------------------------
module depth_to_point_backprojection_unit #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [2:0]           cfg_index,
	input  logic [23:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [15:0]          depth_mm,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   point_x,
	output logic signed [31:0]   point_y,
	output logic [19:0]          point_z,
	output logic                 point_valid,
	output logic [20:0]          valid_so_far,
	output logic                 frame_last
);

	localparam int CW      = $clog2(MAX_COLS);
	localparam int RW      = $clog2(MAX_ROWS);
	localparam int POS_W   = ((CW > RW) ? CW : RW) + 4;
	localparam int MAG_W   = (POS_W > dpbp_pkg::CENTER_W) ? POS_W : dpbp_pkg::CENTER_W;
	localparam int ENTRY_W = 2 * (MAG_W + 1) + dpbp_pkg::META_W;

	dpbp_pkg::cfg_t  cfg_q;
	dpbp_pkg::meta_t f_meta, b_meta;
	logic               push, pop, q_empty, q_full;
	logic               f_neg_x, f_neg_y, b_neg_x, b_neg_y;
	logic [MAG_W-1:0]   f_mag_x, f_mag_y, b_mag_x, b_mag_y;
	logic [ENTRY_W-1:0] push_word, head_word;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= dpbp_pkg::RST_FRAME_WIDTH;
			cfg_q.frame_height <= dpbp_pkg::RST_FRAME_HEIGHT;
			cfg_q.inv_focal_x  <= dpbp_pkg::RST_INV_FOCAL;
			cfg_q.inv_focal_y  <= dpbp_pkg::RST_INV_FOCAL;
			cfg_q.center_x     <= dpbp_pkg::RST_CENTER_X;
			cfg_q.center_y     <= dpbp_pkg::RST_CENTER_Y;
		end else if (cfg_write) begin
			case (cfg_index)
				dpbp_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data[10:0];
				dpbp_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[10:0];
				dpbp_pkg::REG_INV_FOCAL_X:  cfg_q.inv_focal_x  <= cfg_data;
				dpbp_pkg::REG_INV_FOCAL_Y:  cfg_q.inv_focal_y  <= cfg_data;
				dpbp_pkg::REG_CENTER_X:     cfg_q.center_x     <= cfg_data[13:0];
				dpbp_pkg::REG_CENTER_Y:     cfg_q.center_y     <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	// Front end: raster tracking and classification
	dpbp_front #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS),
		.MAG_W    (MAG_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.depth_mm   (depth_mm),
		.queue_full (q_full),
		.push       (push),
		.neg_x      (f_neg_x),
		.mag_x      (f_mag_x),
		.neg_y      (f_neg_y),
		.mag_y      (f_mag_y),
		.meta       (f_meta)
	);

	// Pack words for the queue
	assign push_word = {f_neg_x, f_mag_x, f_neg_y, f_mag_y, f_meta};
	assign {b_neg_x, b_mag_x, b_neg_y, b_mag_y, b_meta} = head_word;

	dpbp_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_word),
		.pop       (pop),
		.head_data (head_word),
		.empty     (q_empty),
		.full      (q_full)
	);

	// Back end: projection pipeline
	dpbp_back #(
		.MAG_W (MAG_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.queue_empty  (q_empty),
		.pop          (pop),
		.neg_x        (b_neg_x),
		.mag_x        (b_mag_x),
		.neg_y        (b_neg_y),
		.mag_y        (b_mag_y),
		.meta         (b_meta),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.point_valid  (point_valid),
		.valid_so_far (valid_so_far),
		.frame_last   (frame_last)
	);

endmodule

FILE: tb/tb_depth_to_point_backprojection_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_depth_to_point_backprojection_unit
// Self-checking bench for the depth back-projection unit. A cycle-free
// predictor tracks the raster counters, the valid count and the register
// file, and computes each point word as the pixel is accepted. A checker
// compares every output word, field by field, against the oldest prediction.
// Directed tests cover defaults, optics and geometry extremes, mid-frame
// geometry changes and unused register indexes. Random tests sweep wide, tall
// and small frames under bursty or back-to-back input and patterned output stall.
// ----------------------------------------------------------------------------
module tb_depth_to_point_backprojection_unit;

	localparam int          MAX_COLS     = 1024;
	localparam int          MAX_ROWS     = 1024;
	localparam int          MAX_REPORTS  = 10;
	localparam logic [2:0]  REG_SPARE_LO = 3'd6;
	localparam logic [2:0]  REG_SPARE_HI = 3'd7;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [19:0]        z;
		logic               valid;
		logic [20:0]        count;
		logic               last;
	} point_t;

	// Block ports
	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cfg_write    = 1'b0;
	logic [2:0]          cfg_index    = '0;
	logic [23:0]         cfg_data     = '0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic [15:0]         depth_mm     = '0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic signed [31:0]  point_x;
	logic signed [31:0]  point_y;
	logic [19:0]         point_z;
	logic                point_valid;
	logic [20:0]         valid_so_far;
	logic                frame_last;

	// Predictor state: register copy, raster counters, valid count
	dpbp_pkg::cfg_t      model_cfg;
	int unsigned         col_pos;
	int unsigned         row_pos;
	logic [20:0]         valid_total;
	point_t              expected_points[$];

	// Bookkeeping
	point_t              head;
	int unsigned         error_count       = 0;
	int unsigned         points_checked    = 0;
	int unsigned         points_with_depth = 0;
	int unsigned         frames_closed     = 0;
	int unsigned         writes_done       = 0;
	int unsigned         burst_left        = 0;
	bit                  sender_steady     = 1'b0;
	stall_mode_t         stall_mode        = STALL_NONE;
	int unsigned         stall_left        = 0;

	depth_to_point_backprojection_unit #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.depth_mm    (depth_mm),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.point_valid (point_valid),
		.valid_so_far(valid_so_far),
		.frame_last  (frame_last)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop for a hung run
	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned limit);
		if (v == 0)
			return 1;
		if (v > limit)
			return limit;
		return v;
	endfunction

	// (16*pos - center) * depth * inv / 2^24, round half away from zero, saturate
	function automatic logic [31:0] backproject_axis(input int unsigned pos,
			input logic [13:0] center, input logic [15:0] depth, input logic [23:0] inv);
		logic signed [63:0] offset;
		logic [63:0]        mag;
		logic [63:0]        q;
		offset = 64'(pos) * 16 - 64'(center);
		mag = (offset < 0) ? -offset : offset;
		q = (mag * depth * inv + 64'd8388608) >> 24;
		if (offset < 0) begin
			if (q > 64'd2147483648)
				q = 64'd2147483648;
			return 32'(-q);
		end
		if (q > 64'd2147483647)
			q = 64'd2147483647;
		return q[31:0];
	endfunction

	// Work out the point word for one accepted pixel and advance the raster
	task automatic predict_point(input logic [15:0] depth);
		int unsigned w;
		int unsigned h;
		logic        row_end;
		logic        last;
		point_t      p;
		w = clamp_dim(model_cfg.frame_width, MAX_COLS);
		h = clamp_dim(model_cfg.frame_height, MAX_ROWS);
		row_end = col_pos >= w - 1;
		last = row_end && (row_pos >= h - 1);
		if (depth != 0) begin
			valid_total = valid_total + 21'd1;
			p.x = backproject_axis(col_pos, model_cfg.center_x, depth, model_cfg.inv_focal_x);
			p.y = backproject_axis(row_pos, model_cfg.center_y, depth, model_cfg.inv_focal_y);
			p.z = {depth, 4'b0000};
			p.valid = 1'b1;
			points_with_depth++;
		end else begin
			p.x = '0;
			p.y = '0;
			p.z = '0;
			p.valid = 1'b0;
		end
		p.count = valid_total;
		p.last = last;
		expected_points.insert(expected_points.size(), p);

		// Wrap at frame end, step to next row at row end
		if (last) begin
			col_pos = 0;
			row_pos = 0;
			valid_total = '0;
			frames_closed++;
		end else if (row_end) begin
			col_pos = 0;
			row_pos++;
		end else begin
			col_pos++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Checker
	// ------------------------------------------------------------------------

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("mismatch: %s", msg);
	endtask

	task automatic compare_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want)
			report_error($sformatf("%s of point word %0d: expected %0d, got %0d",
				name, points_checked, want, got));
	endtask

	// Compare each accepted point word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			points_checked++;
			if (expected_points.size() == 0) begin
				report_error($sformatf("point word %0d arrived with nothing predicted",
					points_checked));
			end else begin
				head = expected_points.pop_front();
				compare_field("point_x", head.x, point_x);
				compare_field("point_y", head.y, point_y);
				compare_field("point_z", head.z, point_z);
				compare_field("point_valid", head.valid, point_valid);
				compare_field("valid_so_far", head.count, valid_so_far);
				compare_field("frame_last", head.last, frame_last);
			end
		end
	end

	// Output stall: switch between free flow, light, heavy and periodic stall
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 120);
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
			default:     out_stall <= ((stall_left % 7) < 3);
		endcase
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Drop valid and hold until every predicted word has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
	endtask

	// Send one depth word; unless sender_steady, insert a random gap after each burst
	task automatic send_depth(input logic [15:0] depth);
		@(negedge clk);
		in_valid <= 1'b1;
		depth_mm <= depth;
		do
			@(posedge clk);
		while (in_stall);
		predict_point(depth);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0 && !sender_steady) begin
			@(negedge clk);
			in_valid <= 1'b0;
			if ($urandom_range(0, 24) == 0)
				wait_drained();
			else
				repeat ($urandom_range(0, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 48);
		end
	endtask

	// Write one register; the block must be idle
	task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			dpbp_pkg::REG_FRAME_WIDTH:  model_cfg.frame_width = value[10:0];
			dpbp_pkg::REG_FRAME_HEIGHT: model_cfg.frame_height = value[10:0];
			dpbp_pkg::REG_INV_FOCAL_X:  model_cfg.inv_focal_x = value;
			dpbp_pkg::REG_INV_FOCAL_Y:  model_cfg.inv_focal_y = value;
			dpbp_pkg::REG_CENTER_X:     model_cfg.center_x = value[13:0];
			dpbp_pkg::REG_CENTER_Y:     model_cfg.center_y = value[13:0];
			default: ;
		endcase
		writes_done++;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_geometry(input logic [23:0] w, input logic [23:0] h);
		write_reg(dpbp_pkg::REG_FRAME_WIDTH, w);
		write_reg(dpbp_pkg::REG_FRAME_HEIGHT, h);
	endtask

	task automatic set_optics(input logic [23:0] fx, input logic [23:0] fy,
			input logic [23:0] cx, input logic [23:0] cy);
		write_reg(dpbp_pkg::REG_INV_FOCAL_X, fx);
		write_reg(dpbp_pkg::REG_INV_FOCAL_Y, fy);
		write_reg(dpbp_pkg::REG_CENTER_X, cx);
		write_reg(dpbp_pkg::REG_CENTER_Y, cy);
	endtask

	// Depth mix: gaps in the measurement, extremes, near range, full range
	function automatic logic [15:0] draw_depth();
		case ($urandom_range(0, 19))
			0, 1, 2: return 16'd0;
			3:       return 16'hFFFF;
			4:       return 16'd1;
			5, 6, 7: return 16'($urandom_range(1, 255));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [23:0] draw_inv_focal();
		case ($urandom_range(0, 9))
			0:       return 24'd0;
			1:       return 24'hFFFFFF;
			2, 3:    return 24'($urandom_range(1, 24'hFFFFFF));
			default: return 24'($urandom_range(20000, 80000));
		endcase
	endfunction

	task automatic randomize_optics();
		set_optics(draw_inv_focal(), draw_inv_focal(),
			24'($urandom_range(0, 16383)), 24'($urandom_range(0, 16383)));
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Registers as left by reset
	task automatic test_default_registers();
		send_depth(16'd0);
		send_depth(16'd1);
		send_depth(16'hFFFF);
		send_depth(16'd1000);
	endtask

	// Focal and center extremes, and a zero reciprocal focal length
	task automatic test_optics_extremes();
		wait_drained();
		set_optics(24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd16383);
		send_depth(16'hFFFF);
		send_depth(16'h8000);
		wait_drained();
		set_optics(24'hFFFFFF, 24'hFFFFFF, 24'd16383, 24'd0);
		send_depth(16'hFFFF);
		send_depth(16'h7FFF);
		wait_drained();
		set_optics(24'd0, 24'd0, 24'd4096, 24'd3392);
		send_depth(16'd1234);
		send_depth(16'd1);
	endtask

	// Zero size acts as one pixel; oversize clamps to the maximum
	task automatic test_degenerate_geometry();
		wait_drained();
		set_optics(24'd45964, 24'd45964, 24'd4096, 24'd3392);
		set_geometry(24'd0, 24'd0);
		send_depth(16'hFFFF);
		send_depth(16'd0);
		send_depth(16'd42);
		wait_drained();
		set_geometry(24'd2047, 24'd2047);
		send_depth(16'd500);
		send_depth(16'd0);
	endtask

	// Shrink the frame mid-row: counters past the new size close the frame
	task automatic test_geometry_shrink();
		wait_drained();
		set_geometry(24'd16, 24'd16);
		repeat (5) send_depth(draw_depth());
		wait_drained();
		set_geometry(24'd3, 24'd1);
		send_depth(16'd777);
		send_depth(16'd0);
	endtask

	// Writes to unused indexes must change nothing
	task automatic test_unused_index();
		wait_drained();
		write_reg(REG_SPARE_LO, 24'hFFFFFF);
		write_reg(REG_SPARE_HI, 24'h000000);
		send_depth(16'd2000);
		send_depth(16'd3);
	endtask

	// One full-width row: every column position, frame wrap at the end
	task automatic test_wide_frame();
		wait_drained();
		set_geometry(24'd1024, 24'd1);
		randomize_optics();
		sender_steady = 1'b0;
		repeat (1030) send_depth(draw_depth());
	endtask

	// One pixel per row over many rows, with the input streaming back to back
	task automatic test_tall_frame();
		wait_drained();
		set_geometry(24'd1, 24'd320);
		randomize_optics();
		sender_steady = 1'b1;
		repeat (330) send_depth(draw_depth());
		sender_steady = 1'b0;
	endtask

	// Small random frames; phases can end mid-frame so geometry changes hit live counters
	task automatic test_random_frames();
		logic [23:0] w;
		logic [23:0] h;
		for (int phase = 0; phase < 8; phase++) begin
			wait_drained();
			case ($urandom_range(0, 7))
				0:       w = 24'd0;
				1:       w = 24'($urandom_range(25, 2047));
				default: w = 24'($urandom_range(1, 24));
			endcase
			case ($urandom_range(0, 7))
				0:       h = 24'd0;
				1:       h = 24'($urandom_range(13, 2047));
				default: h = 24'($urandom_range(1, 12));
			endcase
			set_geometry(w, h);
			randomize_optics();
			sender_steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(40, 100)) send_depth(draw_depth());
		end
		sender_steady = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		model_cfg.frame_width = dpbp_pkg::RST_FRAME_WIDTH;
		model_cfg.frame_height = dpbp_pkg::RST_FRAME_HEIGHT;
		model_cfg.inv_focal_x = dpbp_pkg::RST_INV_FOCAL;
		model_cfg.inv_focal_y = dpbp_pkg::RST_INV_FOCAL;
		model_cfg.center_x = dpbp_pkg::RST_CENTER_X;
		model_cfg.center_y = dpbp_pkg::RST_CENTER_Y;
		col_pos = 0;
		row_pos = 0;
		valid_total = '0;

		// Hold reset, then release it
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		test_default_registers();
		test_optics_extremes();
		test_degenerate_geometry();
		test_geometry_shrink();
		test_unused_index();
		test_wide_frame();
		test_tall_frame();
		test_random_frames();

		// Drain, then allow for the pipeline depth to catch stray words
		wait_drained();
		repeat (12) @(posedge clk);

		$display("Checked %0d point words (%0d with depth) across %0d frame ends.",
			points_checked, points_with_depth, frames_closed);
		$display("Made %0d register writes, covering zero, clamped and unused-index values.",
			writes_done);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches in total", error_count);
			$display("FAIL");
		end
		$finish;
	end

endmodule
